### hw/rtl/isp_pkg.sv
// Shared types, codes and helper functions for the install request stream parser.
// Depends on nothing; imported by isp_step, the top level and the checker.

package isp_pkg;

	// Parser phase, one-hot; order follows the request layout.
	typedef enum logic [12:0] {
		PH_VER     = 13'h0001,
		PH_ACTION  = 13'h0002,
		PH_FMT     = 13'h0004,
		PH_MID     = 13'h0008,
		PH_SENDER  = 13'h0010,
		PH_URLLEN  = 13'h0020,
		PH_PAYLEN  = 13'h0040,
		PH_URL     = 13'h0080,
		PH_MAGIC   = 13'h0100,
		PH_PVER    = 13'h0200,
		PH_STYPE   = 13'h0400,
		PH_SSIZE   = 13'h0800,
		PH_CONTENT = 13'h1000
	} phase_t;

	localparam logic [1:0] ST_ACCEPT   = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;

	localparam logic [3:0] KIND_PARTIAL = 4'd0;
	localparam logic [3:0] KIND_ACTION  = 4'd1;
	localparam logic [3:0] KIND_FMT     = 4'd2;
	localparam logic [3:0] KIND_MID     = 4'd3;
	localparam logic [3:0] KIND_SENDER  = 4'd4;
	localparam logic [3:0] KIND_URLLEN  = 4'd5;
	localparam logic [3:0] KIND_PAYLEN  = 4'd6;
	localparam logic [3:0] KIND_URL     = 4'd7;
	localparam logic [3:0] KIND_MAGIC   = 4'd8;
	localparam logic [3:0] KIND_SECTYPE = 4'd9;
	localparam logic [3:0] KIND_SECSIZE = 4'd10;
	localparam logic [3:0] KIND_CONTENT = 4'd11;

	localparam logic [7:0]  VERSION_BYTE  = 8'h01;
	localparam logic [7:0]  LEB_CONT_MASK = 8'h80;
	localparam logic [31:0] LEB_MAX_BYTES = 32'd5;
	localparam logic [31:0] MAGIC_BYTES   = 32'd4;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] phase_count;
		logic [30:0] total_count;
		logic [31:0] field_accum;
		logic [15:0] url_length;
		logic [31:0] section_length;
	} state_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] bytes_received;
		logic [3:0]  item_kind;
		logic [31:0] item_value;
		logic [31:0] section_offset;
		logic        section_last;
	} result_t;

	localparam state_t STATE_RESET = '{phase: PH_VER, default: '0};

	function automatic state_t enter_phase(state_t s, phase_t p);
		state_t r;
		r = s;
		r.phase = p;
		r.phase_count = '0;
		r.field_accum = '0;
		return r;
	endfunction

	// Byte count of a big-endian header field.
	function automatic logic [31:0] field_need(phase_t p);
		logic [31:0] n;
		case (p)
			PH_FMT, PH_URLLEN: n = 32'd2;
			default: n = 32'd4;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] field_kind(phase_t p);
		logic [3:0] k;
		case (p)
			PH_FMT:    k = KIND_FMT;
			PH_MID:    k = KIND_MID;
			PH_SENDER: k = KIND_SENDER;
			PH_URLLEN: k = KIND_URLLEN;
			PH_PAYLEN: k = KIND_PAYLEN;
			default:   k = KIND_PARTIAL;
		endcase
		return k;
	endfunction

	// Phase after a header field; an empty URL skips to the magic bytes.
	function automatic phase_t field_next(phase_t p, logic [15:0] url_len);
		phase_t n;
		case (p)
			PH_FMT:    n = PH_MID;
			PH_MID:    n = PH_SENDER;
			PH_SENDER: n = PH_URLLEN;
			PH_URLLEN: n = PH_PAYLEN;
			default:   n = (url_len == 16'd0) ? PH_MAGIC : PH_URL;
		endcase
		return n;
	endfunction

	// Expected magic (00 61 73 6d) or payload version (01 00 00 00) byte.
	function automatic logic [7:0] expected_id(logic is_magic, logic [1:0] idx);
		logic [7:0] e;
		case (idx)
			2'd0:    e = is_magic ? 8'h00 : 8'h01;
			2'd1:    e = is_magic ? 8'h61 : 8'h00;
			2'd2:    e = is_magic ? 8'h73 : 8'h00;
			default: e = is_magic ? 8'h6d : 8'h00;
		endcase
		return e;
	endfunction

endpackage

### hw/rtl/isp_step.sv
// Combinational per-byte parse step: next parser state and the result item.
// Depends on isp_pkg.

module isp_step import isp_pkg::*; (
	input  state_t      st,
	input  logic [7:0]  data_byte,
	input  logic [30:0] request_length,
	output state_t      nxt,
	output result_t     res
);

	logic [31:0] pc_inc;
	logic [31:0] accum_sh;
	logic [31:0] leb_bits;
	logic [31:0] sl_new;
	logic        reject;
	logic        sec_end;
	logic        complete;

	assign pc_inc   = st.phase_count + 32'd1;
	assign accum_sh = {st.field_accum[23:0], data_byte};
	assign sl_new   = st.section_length | leb_bits;

	// Place the seven payload bits of an LEB128 byte; fifth byte drops bits above 31.
	always_comb begin
		case (st.phase_count[2:0])
			3'd0:    leb_bits = {25'd0, data_byte[6:0]};
			3'd1:    leb_bits = {18'd0, data_byte[6:0], 7'd0};
			3'd2:    leb_bits = {11'd0, data_byte[6:0], 14'd0};
			3'd3:    leb_bits = {4'd0, data_byte[6:0], 21'd0};
			3'd4:    leb_bits = {data_byte[3:0], 28'd0};
			default: leb_bits = 32'd0;
		endcase
	end

	always_comb begin
		nxt = st;
		nxt.total_count = st.total_count + 31'd1;
		reject = 1'b0;
		sec_end = 1'b0;
		complete = 1'b0;
		res.status = ST_ACCEPT;
		res.item_kind = KIND_PARTIAL;
		res.item_value = {24'd0, data_byte};
		res.section_offset = '0;
		res.section_last = 1'b0;

		case (st.phase)
			PH_ACTION: begin
				res.item_kind = KIND_ACTION;
				nxt = enter_phase(nxt, PH_FMT);
			end
			PH_FMT, PH_MID, PH_SENDER, PH_URLLEN, PH_PAYLEN: begin
				nxt.field_accum = accum_sh;
				nxt.phase_count = pc_inc;
				if (pc_inc >= field_need(st.phase)) begin
					res.item_kind = field_kind(st.phase);
					res.item_value = accum_sh;
					if (st.phase == PH_URLLEN) begin
						nxt.url_length = accum_sh[15:0];
					end
					nxt = enter_phase(nxt, field_next(st.phase, st.url_length));
				end
			end
			PH_URL: begin
				res.item_kind = KIND_URL;
				nxt.phase_count = pc_inc;
				if (pc_inc >= {16'd0, st.url_length}) begin
					nxt = enter_phase(nxt, PH_MAGIC);
				end
			end
			PH_MAGIC, PH_PVER: begin
				if (data_byte != expected_id(st.phase == PH_MAGIC, st.phase_count[1:0])) begin
					reject = 1'b1;
				end else begin
					res.item_kind = KIND_MAGIC;
					nxt.phase_count = pc_inc;
					if (pc_inc >= MAGIC_BYTES) begin
						nxt = enter_phase(nxt, (st.phase == PH_MAGIC) ? PH_PVER : PH_STYPE);
					end
				end
			end
			PH_STYPE: begin
				res.item_kind = KIND_SECTYPE;
				nxt = enter_phase(nxt, PH_SSIZE);
				nxt.section_length = '0;
			end
			PH_SSIZE: begin
				if (st.phase_count >= LEB_MAX_BYTES) begin
					reject = 1'b1;
				end else begin
					nxt.section_length = sl_new;
					nxt.phase_count = pc_inc;
					if ((data_byte & LEB_CONT_MASK) == 8'd0) begin
						res.item_kind = KIND_SECSIZE;
						res.item_value = sl_new;
						nxt = enter_phase(nxt, PH_CONTENT);
						if (sl_new == 32'd0) begin
							sec_end = 1'b1;
						end
					end
				end
			end
			PH_CONTENT: begin
				res.item_kind = KIND_CONTENT;
				res.section_offset = st.phase_count;
				nxt.phase_count = pc_inc;
				if (pc_inc == st.section_length) begin
					res.section_last = 1'b1;
					sec_end = 1'b1;
				end
			end
			default: begin
				// version byte: restart the request
				nxt = STATE_RESET;
				nxt.total_count = 31'd1;
				if (data_byte != VERSION_BYTE) begin
					reject = 1'b1;
				end else begin
					nxt = enter_phase(nxt, PH_ACTION);
				end
			end
		endcase

		res.bytes_received = nxt.total_count;

		if (sec_end) begin
			if (nxt.total_count == request_length) begin
				complete = 1'b1;
			end else begin
				nxt = enter_phase(nxt, PH_STYPE);
			end
		end

		if (reject) begin
			res.status = ST_REJECT;
			res.item_kind = KIND_PARTIAL;
			res.item_value = {24'd0, data_byte};
			res.section_offset = '0;
			res.section_last = 1'b0;
			nxt = STATE_RESET;
		end else if (complete) begin
			res.status = ST_COMPLETE;
			nxt = STATE_RESET;
		end
	end

endmodule

### hw/rtl/install_request_stream_parser.sv
// Latency: an accepted byte passes the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle while out_ready drains the result register; state and step logic form a loop.
// The input register can take a new item while a finished result waits for out_ready.
// Reset (arst_n low, asynchronous): parser returns to the version phase, all counts
// and fields clear, both registers empty.
// Depends on isp_pkg and isp_step.

module install_request_stream_parser import isp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [30:0] request_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [30:0] bytes_received,
	output logic [3:0]  item_kind,
	output logic [31:0] item_value,
	output logic [31:0] section_offset,
	output logic        section_last
);

	// Input register stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [30:0] req_len_s1;

	// Parser state and result register
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;

	logic in_fire;
	logic advance;

	// Advance the held byte when the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
			req_len_s1 <= request_length;
		end
	end

	isp_step u_step (
		.st             (state_q),
		.data_byte      (byte_s1),
		.request_length (req_len_s1),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// Parser state updates once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	// Drive the result ports straight from the result register.
	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign bytes_received = res_q.bytes_received;
	assign item_kind      = res_q.item_kind;
	assign item_value     = res_q.item_value;
	assign section_offset = res_q.section_offset;
	assign section_last   = res_q.section_last;

endmodule

### hw/rtl/isp_checker.sv
// Port-level assertions for the install request stream parser, and the bind
// that attaches them to the top level. Depends on isp_pkg.

module isp_checker import isp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic [30:0] request_length,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [30:0] bytes_received,
	input logic [3:0]  item_kind,
	input logic [31:0] item_value,
	input logic [31:0] section_offset,
	input logic        section_last
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_ACCEPT || status == ST_REJECT || status == ST_COMPLETE))
		else $error("status code out of range");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_REJECT) |->
		(item_kind == KIND_PARTIAL && section_offset == 32'd0 && !section_last))
		else $error("rejected item carries field data");

	a_complete_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_COMPLETE) |->
		(item_kind == KIND_SECSIZE || item_kind == KIND_CONTENT))
		else $error("request completed outside a section end");

	a_offset_content: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind != KIND_CONTENT) |-> (section_offset == 32'd0 && !section_last))
		else $error("section offset on a non-content item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(item_value) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind install_request_stream_parser isp_checker u_isp_checker (.*);
